/* hdl/rws_pkg.sv */
// Shared types and constants for the roulette wheel selector.
package rws_pkg;

	// Width and reset value of the wheel size register.
	localparam int unsigned CFG_BITS  = 8;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 8'd128;

	// Operation codes carried by an input beat.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// Token travelling from cell to cell during a walk.
	typedef struct packed {
		logic tok;    // token present at this link
		logic found;  // an earlier cell already claimed the walk
	} link_t;

	// Per-cell control, driven from the sequencer.
	typedef struct packed {
		logic wr_en;    // load the broadcast prefix sum into this cell
		logic is_last;  // this cell is the last entry in use
		logic search;   // walk compares against the threshold (else fetches total)
	} cell_ctl_t;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_FETCH  = 5'b00010,
		ST_MUL    = 5'b00100,
		ST_SEARCH = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

endpackage

/* hdl/rws_cell.sv */
// One wheel cell: holds one prefix sum and forwards the walk token to its neighbor.
module rws_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned DW    = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rws_pkg::cell_ctl_t ctl,
	input  logic [DW-1:0]     wr_data,
	input  rws_pkg::link_t    link_in,
	input  logic [DW-1:0]     data_in,
	output rws_pkg::link_t    link_out,
	output logic [DW-1:0]     data_out
);
	import rws_pkg::*;

	logic [DW-1:0] sum_q;
	link_t         link_q;
	logic [DW-1:0] data_q;
	link_t         link_d;
	logic [DW-1:0] data_d;

	// Claim the walk at the first qualifying cell; later cells pass it on.
	always_comb begin
		link_d = link_in;
		data_d = data_in;
		if (link_in.tok && !link_in.found) begin
			if (ctl.search) begin
				if (ctl.is_last || (sum_q >= data_in)) begin
					link_d.found = 1'b1;
					data_d       = DW'(INDEX);
				end
			end else if (ctl.is_last) begin
				link_d.found = 1'b1;
				data_d       = sum_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q <= link_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
		if (ctl.wr_en) begin
			sum_q <= wr_data;
		end
	end

	assign link_out = link_q;
	assign data_out = data_q;

endmodule

/* hdl/rws_ctrl.sv */
// Sequencer: load bookkeeping, walk launch, threshold multiply and result register.
module rws_ctrl #(
	parameter int unsigned MAX_ENTRIES = 128,
	parameter int unsigned WEIGHT_BITS = 24,
	parameter int unsigned RANDOM_BITS = 16,
	parameter int unsigned IDX_W       = $clog2(MAX_ENTRIES),
	parameter int unsigned DW          = WEIGHT_BITS + $clog2(MAX_ENTRIES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [WEIGHT_BITS-1:0]        weight,
	input  logic [RANDOM_BITS-1:0]        random_fraction,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [IDX_W-1:0]              selected_index,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rws_pkg::CFG_BITS-1:0]  entries_in_use,
	output rws_pkg::link_t                head_link,
	output logic [DW-1:0]                 head_data,
	input  rws_pkg::link_t                end_link,
	input  logic [DW-1:0]                 end_data,
	output logic                          wr_en,
	output logic [IDX_W-1:0]              wr_pos,
	output logic [DW-1:0]                 wr_data,
	output logic [IDX_W-1:0]              last,
	output logic                          search
);
	import rws_pkg::*;

	localparam int unsigned LW = (IDX_W + 1 > CFG_BITS) ? IDX_W + 1 : CFG_BITS;
	localparam int unsigned PW = RANDOM_BITS + DW;

	state_t                 state_q;
	logic [CFG_BITS-1:0]    cfg_q;
	logic [IDX_W-1:0]       pos_q;
	logic [DW-1:0]          run_q;
	logic [RANDOM_BITS-1:0] frac_q;
	logic [DW-1:0]          total_q;
	logic                   head_tok_q;
	logic [DW-1:0]          head_data_q;
	logic [IDX_W-1:0]       res_q;
	logic                   out_valid_q;
	logic [IDX_W-1:0]       out_idx_q;

	logic [LW-1:0]    cfg_ext;
	logic [IDX_W-1:0] pos_eff;
	logic [DW-1:0]    base;
	logic [DW:0]      sum_w;
	logic [DW-1:0]    sum_sat;
	logic [PW-1:0]    prod;
	logic             in_fire;
	logic             slot_free;

	// Clamp the wheel size to 1..MAX_ENTRIES and express it as the last index.
	always_comb begin
		cfg_ext = LW'(cfg_q);
		if (cfg_ext == '0) begin
			last = '0;
		end else if (cfg_ext > LW'(MAX_ENTRIES)) begin
			last = IDX_W'(MAX_ENTRIES - 1);
		end else begin
			last = IDX_W'(cfg_ext - LW'(1));
		end
	end

	// Wrap a stale position, restart the running sum at position zero, saturate.
	always_comb begin
		pos_eff = (pos_q > last) ? '0 : pos_q;
		base    = (pos_eff == '0) ? '0 : run_q;
		sum_w   = {1'b0, base} + (DW + 1)'(weight);
		sum_sat = sum_w[DW] ? '1 : sum_w[DW-1:0];
	end

	assign prod      = PW'(frac_q) * PW'(total_q);
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign wr_en   = in_fire && (operation == OP_LOAD);
	assign wr_pos  = pos_eff;
	assign wr_data = sum_sat;
	assign search  = (state_q == ST_SEARCH);

	assign head_link.tok   = head_tok_q;
	assign head_link.found = 1'b0;
	assign head_data       = head_data_q;

	assign out_valid      = out_valid_q;
	assign selected_index = out_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_RESET;
			pos_q       <= '0;
			run_q       <= '0;
			head_tok_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Launch a walk for a new draw and again once the threshold is ready.
			head_tok_q <= (in_fire && (operation == OP_DRAW)) || (state_q == ST_MUL);
			if (cfg_valid && cfg_ready) begin
				cfg_q <= entries_in_use;
			end
			if ((state_q == ST_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (operation == OP_LOAD) begin
							run_q <= sum_sat;
							pos_q <= (pos_eff == last) ? '0 : pos_eff + IDX_W'(1);
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					if (end_link.tok) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (end_link.tok) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			frac_q <= random_fraction;
		end
		if ((state_q == ST_FETCH) && end_link.tok) begin
			total_q <= end_data;
		end
		if (state_q == ST_MUL) begin
			head_data_q <= prod[RANDOM_BITS +: DW];
		end
		if ((state_q == ST_SEARCH) && end_link.tok) begin
			res_q <= end_data[IDX_W-1:0];
		end
		if ((state_q == ST_DONE) && slot_free) begin
			out_idx_q <= res_q;
		end
	end

endmodule

/* hdl/roulette_wheel_selector_top.sv */
// Top level of the roulette wheel selector: sequencer plus the row of wheel cells.
//
// Fitness-proportional selector. A load beat (operation 0) writes the next weight
// into a running prefix-sum table held in a row of MAX_ENTRIES cells, one sum per
// cell; position zero starts a new pass and the position wraps after
// entries_in_use loads (0 acts as 1, values above MAX_ENTRIES act as MAX_ENTRIES).
// Sums saturate at all ones. A load gives no result beat.
// A draw beat (operation 1) gives one result beat: it sends a token down the
// cell row to pick up the total from the last entry in use, multiplies the
// random fraction by that total to form the threshold, then sends a second
// token down the row that stops at the first cell whose sum reaches the
// threshold, or at the last entry in use. Each walk moves one cell per cycle
// over the full row, so a draw occupies the block from acceptance until its
// result is registered for output. Loads and configuration writes are taken
// only between draws. A finished index waits in an output register, so the
// next beat can be accepted while the result has not yet been taken. Reading
// an entry never loaded in the current setup returns an undefined index.
module roulette_wheel_selector_top #(
	parameter int unsigned MAX_ENTRIES = 128,
	parameter int unsigned WEIGHT_BITS = 24,
	parameter int unsigned RANDOM_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [WEIGHT_BITS-1:0]              weight,
	input  logic [RANDOM_BITS-1:0]              random_fraction,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [$clog2(MAX_ENTRIES)-1:0]      selected_index,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rws_pkg::CFG_BITS-1:0]        entries_in_use
);
	import rws_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
	// Sum width grows by the index width so a full wheel of top weights fits.
	localparam int unsigned DW    = WEIGHT_BITS + IDX_W;

	link_t            link [MAX_ENTRIES+1];
	logic [DW-1:0]    data [MAX_ENTRIES+1];
	logic             wr_en;
	logic [IDX_W-1:0] wr_pos;
	logic [DW-1:0]    wr_data;
	logic [IDX_W-1:0] last;
	logic             search;

	rws_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.RANDOM_BITS (RANDOM_BITS),
		.IDX_W       (IDX_W),
		.DW          (DW)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.weight          (weight),
		.random_fraction (random_fraction),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.selected_index  (selected_index),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.entries_in_use  (entries_in_use),
		.head_link       (link[0]),
		.head_data       (data[0]),
		.end_link        (link[MAX_ENTRIES]),
		.end_data        (data[MAX_ENTRIES]),
		.wr_en           (wr_en),
		.wr_pos          (wr_pos),
		.wr_data         (wr_data),
		.last            (last),
		.search          (search)
	);

	// Row of cells: each hands the walk token and its payload to the next one.
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		cell_ctl_t ctl;

		// Decode the write strobe and the last-entry mark for this cell.
		assign ctl.wr_en   = wr_en && (wr_pos == IDX_W'(i));
		assign ctl.is_last = (last == IDX_W'(i));
		assign ctl.search  = search;

		rws_cell #(
			.INDEX (i),
			.DW    (DW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_data  (wr_data),
			.link_in  (link[i]),
			.data_in  (data[i]),
			.link_out (link[i+1]),
			.data_out (data[i+1])
		);
	end

endmodule
